### design/ffha_pkg.sv
// Shared types and constants for the first-fit heap allocator.
// Depends on nothing; the top level and the checker import it.
package ffha_pkg;

  localparam int unsigned REQ_W          = 17;
  localparam int unsigned OFFS_W         = 16;
  localparam int unsigned CFG_W          = 17;
  localparam int unsigned HEADER_BYTES   = 8;
  localparam int unsigned MIN_HEAP_BYTES = 4096;
  localparam int unsigned RESET_HEAP     = 65536;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
  localparam logic [1:0] STATUS_BAD_FREE = 2'd2;

  typedef struct packed {
    logic              cmd;
    logic [REQ_W-1:0]  request_bytes;
    logic [OFFS_W-1:0] free_offset;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [OFFS_W-1:0] result_offset;
  } rsp_t;

endpackage

### design/ffha_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// Depends on nothing.
module ffha_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

### design/first_fit_heap_allocator.sv
// First-fit heap allocator top level: sequencer around a header RAM and a free-list RAM.
// Depends on ffha_pkg and ffha_ram.
//
// Usage: an item on the input channel (in_valid_i / in_stall_o) is either an
// allocate (cmd 0, request_bytes) or a free (cmd 1, free_offset). Each item
// gives exactly one result item on the output channel (out_valid_o /
// out_stall_i) with a status and, for a good allocate, the data offset.
// Chunk headers live in one RAM indexed by word offset, the address-ordered
// free list in a second RAM. Both have a registered read, so the sequencer
// scans each free-list entry on allocate through S_A_LRD, S_A_HRD and S_A_CMP,
// walks each chunk on free through S_F_RD and S_F_CHK, and searches or shifts
// each list entry through a read state and a compare or write state.
// A zero-size allocate goes straight to S_DONE; latency grows with fragmentation,
// and an item is taken only when the previous one is finished.
// The result sits in an output register, so a new item is accepted while
// the receiver stalls the previous result; the sequencer waits only when a
// second result is ready before the first has been taken.
// The heap_bytes register is written through cfg_valid_i / cfg_ready_o while
// idle and reinitializes the heap in S_INIT. After reset the block writes the
// initial free chunk in S_INIT and then accepts items.
module first_fit_heap_allocator #(
  parameter int unsigned HEAP_BYTES      = 65536,
  parameter int unsigned MIN_SPLIT_BYTES = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  ffha_pkg::req_t           in_item_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output ffha_pkg::rsp_t           out_item_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [ffha_pkg::CFG_W-1:0] cfg_data_i
);
  import ffha_pkg::*;

  localparam int unsigned WORDS  = HEAP_BYTES / 4;
  localparam int unsigned LDEPTH = HEAP_BYTES / HEADER_BYTES;
  localparam int unsigned OW     = $clog2(HEAP_BYTES);
  localparam int unsigned SZ_W   = $clog2(HEAP_BYTES + 1);
  localparam int unsigned HW     = $clog2(WORDS);
  localparam int unsigned LW     = $clog2(LDEPTH);
  localparam int unsigned CNT_W  = $clog2(LDEPTH + 1);
  localparam int unsigned NEED_W = REQ_W + 1;
  localparam int unsigned CW     = ((SZ_W > NEED_W) ? SZ_W : NEED_W) + 2;
  localparam int unsigned RST_HEAP = (RESET_HEAP > HEAP_BYTES) ? HEAP_BYTES : RESET_HEAP;

  localparam logic [4:0] S_INIT     = 5'd0;
  localparam logic [4:0] S_IDLE     = 5'd1;
  localparam logic [4:0] S_A_LRD    = 5'd2;
  localparam logic [4:0] S_A_HRD    = 5'd3;
  localparam logic [4:0] S_A_CMP    = 5'd4;
  localparam logic [4:0] S_A_SPLIT  = 5'd5;
  localparam logic [4:0] S_RM_RD    = 5'd6;
  localparam logic [4:0] S_RM_WR    = 5'd7;
  localparam logic [4:0] S_F_RD     = 5'd8;
  localparam logic [4:0] S_F_CHK    = 5'd9;
  localparam logic [4:0] S_F_NCHK   = 5'd10;
  localparam logic [4:0] S_F_DEC    = 5'd11;
  localparam logic [4:0] S_FIND_RD  = 5'd12;
  localparam logic [4:0] S_FIND_CMP = 5'd13;
  localparam logic [4:0] S_FIND_END = 5'd14;
  localparam logic [4:0] S_INS_RD   = 5'd15;
  localparam logic [4:0] S_INS_WR   = 5'd16;
  localparam logic [4:0] S_DONE     = 5'd17;

  localparam logic [1:0] FM_BOTH = 2'd0;
  localparam logic [1:0] FM_NEXT = 2'd1;
  localparam logic [1:0] FM_PF   = 2'd2;

  logic [4:0]        state_q, state_d;
  logic [SZ_W-1:0]   heap_q, heap_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  tgt_q, tgt_d;
  logic [NEED_W-1:0] need_q, need_d;
  logic [OFFS_W-1:0] target_q, target_d;
  logic [OW-1:0]     off_q, off_d;
  logic [SZ_W-1:0]   sz_q, sz_d;
  logic [OW-1:0]     prev_q, prev_d;
  logic [SZ_W-1:0]   prev_sz_q, prev_sz_d;
  logic              prev_free_q, prev_free_d;
  logic              have_prev_q, have_prev_d;
  logic [OW-1:0]     pf_q, pf_d;
  logic              have_pf_q, have_pf_d;
  logic [OW-1:0]     nxt_q, nxt_d;
  logic [SZ_W-1:0]   nxt_sz_q, nxt_sz_d;
  logic              nfree_q, nfree_d;
  logic [1:0]        mode_q, mode_d;
  logic [OW-1:0]     fkey_q, fkey_d;
  rsp_t              res_q, res_d;
  rsp_t              out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic              hdr_we;
  logic [HW-1:0]     hdr_waddr, hdr_raddr;
  logic [SZ_W:0]     hdr_wdata, hdr_rdata;
  logic              lst_we;
  logic [LW-1:0]     lst_waddr, lst_raddr;
  logic [OW-1:0]     lst_wdata, lst_rdata;

  logic [SZ_W-1:0]   hdr_sz;
  logic              hdr_fr;
  logic [CW-1:0]     off_x, sum_x, heap_x, left_x, cfg_x, round_x;
  logic              hit, small_left, in_acc;

  ffha_ram #(.WIDTH(SZ_W + 1), .DEPTH(WORDS)) u_hdr_ram (
    .clk_i  (clk_i),
    .we_i   (hdr_we),
    .waddr_i(hdr_waddr),
    .wdata_i(hdr_wdata),
    .raddr_i(hdr_raddr),
    .rdata_o(hdr_rdata)
  );

  ffha_ram #(.WIDTH(OW), .DEPTH(LDEPTH)) u_list_ram (
    .clk_i  (clk_i),
    .we_i   (lst_we),
    .waddr_i(lst_waddr),
    .wdata_i(lst_wdata),
    .raddr_i(lst_raddr),
    .rdata_o(lst_rdata)
  );

  assign hdr_sz      = hdr_rdata[SZ_W-1:0];
  assign hdr_fr      = hdr_rdata[SZ_W];
  assign off_x       = CW'(off_q);
  assign sum_x       = off_x + CW'(hdr_sz);
  assign heap_x      = CW'(heap_q);
  assign left_x      = CW'(hdr_sz) - CW'(need_q);
  assign hit         = (off_x + CW'(HEADER_BYTES)) == CW'(target_q);
  assign small_left  = (left_x < CW'(MIN_SPLIT_BYTES)) || (left_x < CW'(HEADER_BYTES));
  assign in_stall_o  = (state_q != S_IDLE) || cfg_valid_i;
  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;

  // Clamp the written heap size to the minimum, round up to a word, then clamp to HEAP_BYTES.
  always_comb begin
    cfg_x = CW'(cfg_data_i);
    if (cfg_x < CW'(MIN_HEAP_BYTES)) begin
      cfg_x = CW'(MIN_HEAP_BYTES);
    end
    round_x = (cfg_x + CW'(3)) & ~CW'(3);
    if (round_x > CW'(HEAP_BYTES)) begin
      round_x = CW'(HEAP_BYTES);
    end
  end

  always_comb begin
    state_d     = state_q;
    heap_d      = heap_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    tgt_d       = tgt_q;
    need_d      = need_q;
    target_d    = target_q;
    off_d       = off_q;
    sz_d        = sz_q;
    prev_d      = prev_q;
    prev_sz_d   = prev_sz_q;
    prev_free_d = prev_free_q;
    have_prev_d = have_prev_q;
    pf_d        = pf_q;
    have_pf_d   = have_pf_q;
    nxt_d       = nxt_q;
    nxt_sz_d    = nxt_sz_q;
    nfree_d     = nfree_q;
    mode_d      = mode_q;
    fkey_d      = fkey_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    hdr_we      = 1'b0;
    hdr_waddr   = off_q[OW-1:2];
    hdr_wdata   = {1'b1, sz_q};
    hdr_raddr   = off_q[OW-1:2];
    lst_we      = 1'b0;
    lst_waddr   = idx_q[LW-1:0];
    lst_wdata   = off_q;
    lst_raddr   = idx_q[LW-1:0];

    unique case (state_q)
      S_INIT: begin
        hdr_we    = 1'b1;
        hdr_waddr = '0;
        hdr_wdata = {1'b1, heap_q};
        lst_we    = 1'b1;
        lst_waddr = '0;
        lst_wdata = '0;
        cnt_d     = CNT_W'(1);
        state_d   = S_IDLE;
      end
      S_IDLE: begin
        if (cfg_valid_i) begin
          heap_d  = SZ_W'(round_x);
          state_d = S_INIT;
        end else if (in_acc) begin
          res_d    = '{status: STATUS_OK, result_offset: '0};
          target_d = in_item_i.free_offset;
          idx_d    = '0;
          off_d    = '0;
          need_d   = NEED_W'((NEED_W'(in_item_i.request_bytes) + NEED_W'(3)) & ~NEED_W'(3))
                     + NEED_W'(HEADER_BYTES);
          have_prev_d = 1'b0;
          have_pf_d   = 1'b0;
          if (in_item_i.cmd == CMD_FREE) begin
            state_d = S_F_RD;
          end else if (in_item_i.request_bytes == '0 || cnt_q == '0) begin
            res_d.status = STATUS_NO_SPACE;
            state_d      = S_DONE;
          end else begin
            state_d = S_A_LRD;
          end
        end
      end
      S_A_LRD: begin
        state_d = S_A_HRD;
      end
      S_A_HRD: begin
        off_d     = lst_rdata;
        hdr_raddr = lst_rdata[OW-1:2];
        state_d   = S_A_CMP;
      end
      S_A_CMP: begin
        if (CW'(hdr_sz) >= CW'(need_q)) begin
          res_d.result_offset = OFFS_W'(off_x + CW'(HEADER_BYTES));
          hdr_we = 1'b1;
          if (small_left) begin
            hdr_wdata = {1'b0, hdr_sz};
            state_d   = S_RM_RD;
          end else begin
            hdr_wdata = {1'b0, SZ_W'(need_q)};
            nxt_d     = OW'(off_x + CW'(need_q));
            nxt_sz_d  = SZ_W'(left_x);
            lst_we    = 1'b1;
            lst_wdata = OW'(off_x + CW'(need_q));
            state_d   = S_A_SPLIT;
          end
        end else if (idx_q + CNT_W'(1) < cnt_q) begin
          idx_d   = idx_q + CNT_W'(1);
          state_d = S_A_LRD;
        end else begin
          res_d.status = STATUS_NO_SPACE;
          state_d      = S_DONE;
        end
      end
      S_A_SPLIT: begin
        hdr_we    = 1'b1;
        hdr_waddr = nxt_q[OW-1:2];
        hdr_wdata = {1'b1, nxt_sz_q};
        state_d   = S_DONE;
      end
      S_RM_RD: begin
        // Close the gap left by the removed entry, moving each later entry down through S_RM_RD and S_RM_WR.
        if (idx_q + CNT_W'(1) < cnt_q) begin
          lst_raddr = LW'(idx_q + CNT_W'(1));
          state_d   = S_RM_WR;
        end else begin
          cnt_d   = cnt_q - CNT_W'(1);
          state_d = S_DONE;
        end
      end
      S_RM_WR: begin
        lst_we    = 1'b1;
        lst_wdata = lst_rdata;
        idx_d     = idx_q + CNT_W'(1);
        state_d   = S_RM_RD;
      end
      S_F_RD: begin
        state_d = S_F_CHK;
      end
      S_F_CHK: begin
        if (hit) begin
          sz_d = hdr_sz;
          if (hdr_fr) begin
            res_d.status = STATUS_BAD_FREE;
            state_d      = S_DONE;
          end else if (sum_x < heap_x) begin
            nxt_d     = OW'(sum_x);
            hdr_raddr = sum_x[OW-1:2];
            state_d   = S_F_NCHK;
          end else begin
            nfree_d = 1'b0;
            state_d = S_F_DEC;
          end
        end else if (hdr_sz == '0) begin
          res_d.status = STATUS_BAD_FREE;
          state_d      = S_DONE;
        end else begin
          if (hdr_fr) begin
            pf_d      = off_q;
            have_pf_d = 1'b1;
          end
          prev_d      = off_q;
          prev_sz_d   = hdr_sz;
          prev_free_d = hdr_fr;
          have_prev_d = 1'b1;
          if (sum_x < heap_x) begin
            off_d   = OW'(sum_x);
            state_d = S_F_RD;
          end else begin
            res_d.status = STATUS_BAD_FREE;
            state_d      = S_DONE;
          end
        end
      end
      S_F_NCHK: begin
        nfree_d  = hdr_fr;
        nxt_sz_d = hdr_sz;
        state_d  = S_F_DEC;
      end
      S_F_DEC: begin
        idx_d  = '0;
        fkey_d = nxt_q;
        if (have_prev_q && prev_free_q) begin
          hdr_we    = 1'b1;
          hdr_waddr = prev_q[OW-1:2];
          if (nfree_q) begin
            hdr_wdata = {1'b1, SZ_W'(CW'(prev_sz_q) + CW'(sz_q) + CW'(nxt_sz_q))};
            mode_d    = FM_BOTH;
            state_d   = S_FIND_RD;
          end else begin
            hdr_wdata = {1'b1, SZ_W'(CW'(prev_sz_q) + CW'(sz_q))};
            state_d   = S_DONE;
          end
        end else if (nfree_q) begin
          hdr_we    = 1'b1;
          hdr_wdata = {1'b1, SZ_W'(CW'(sz_q) + CW'(nxt_sz_q))};
          mode_d    = FM_NEXT;
          state_d   = S_FIND_RD;
        end else if (CW'(cnt_q) >= CW'(LDEPTH)) begin
          res_d.status = STATUS_BAD_FREE;
          state_d      = S_DONE;
        end else begin
          hdr_we = 1'b1;
          if (have_pf_q) begin
            fkey_d  = pf_q;
            mode_d  = FM_PF;
            state_d = S_FIND_RD;
          end else begin
            tgt_d   = '0;
            idx_d   = cnt_q;
            state_d = S_INS_RD;
          end
        end
      end
      S_FIND_RD: begin
        if (idx_q < cnt_q) begin
          state_d = S_FIND_CMP;
        end else begin
          state_d = S_FIND_END;
        end
      end
      S_FIND_CMP: begin
        if (lst_rdata == fkey_q) begin
          state_d = S_FIND_END;
        end else begin
          idx_d   = idx_q + CNT_W'(1);
          state_d = S_FIND_RD;
        end
      end
      S_FIND_END: begin
        unique case (mode_q)
          FM_BOTH: begin
            state_d = (idx_q < cnt_q) ? S_RM_RD : S_DONE;
          end
          FM_NEXT: begin
            lst_we  = (idx_q < cnt_q);
            state_d = S_DONE;
          end
          default: begin
            // Insert just after the last free chunk below the released one.
            tgt_d   = (idx_q < cnt_q) ? idx_q + CNT_W'(1) : cnt_q;
            idx_d   = cnt_q;
            state_d = S_INS_RD;
          end
        endcase
      end
      S_INS_RD: begin
        if (idx_q > tgt_q) begin
          lst_raddr = LW'(idx_q - CNT_W'(1));
          state_d   = S_INS_WR;
        end else begin
          lst_we  = 1'b1;
          cnt_d   = cnt_q + CNT_W'(1);
          state_d = S_DONE;
        end
      end
      S_INS_WR: begin
        lst_we    = 1'b1;
        lst_wdata = lst_rdata;
        idx_d     = idx_q - CNT_W'(1);
        state_d   = S_INS_RD;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      heap_q      <= SZ_W'(RST_HEAP);
      cnt_q       <= CNT_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      heap_q      <= heap_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    tgt_q       <= tgt_d;
    need_q      <= need_d;
    target_q    <= target_d;
    off_q       <= off_d;
    sz_q        <= sz_d;
    prev_q      <= prev_d;
    prev_sz_q   <= prev_sz_d;
    prev_free_q <= prev_free_d;
    have_prev_q <= have_prev_d;
    pf_q        <= pf_d;
    have_pf_q   <= have_pf_d;
    nxt_q       <= nxt_d;
    nxt_sz_q    <= nxt_sz_d;
    nfree_q     <= nfree_d;
    mode_q      <= mode_d;
    fkey_q      <= fkey_d;
    res_q       <= res_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
endmodule

### design/ffha_checker.sv
// Port-level checks for the first-fit heap allocator, bound to the top level.
// Depends on ffha_pkg and first_fit_heap_allocator.
module ffha_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input ffha_pkg::rsp_t             out_item_o,
  input logic                       cfg_valid_i,
  input logic                       cfg_ready_o
);
  import ffha_pkg::*;

  // A stalled result stays put.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // Failed items never carry an offset.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != STATUS_OK |-> out_item_o.result_offset == '0)
    else $error("failed item carries an offset");

  // A nonzero offset is a word-aligned data offset past a header.
  a_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.result_offset != '0 |->
      out_item_o.result_offset[1:0] == 2'b00 && out_item_o.result_offset >= 16'(HEADER_BYTES))
    else $error("misaligned data offset");

  // A configuration write is followed by reinitialization (S_INIT), in which no item is taken.
  a_cfg_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> in_stall_o && !cfg_ready_o)
    else $error("item taken during heap reinit");
endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_item_o (out_item_o),
  .cfg_valid_i(cfg_valid_i),
  .cfg_ready_o(cfg_ready_o)
);
